[rtl/core/pme_pkg.sv]
// Shared types and constants for the permutation mutation engine.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package pme_pkg;

  localparam int unsigned TourDepth = 32;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned CityW     = 5;
  localparam int unsigned GenW      = 48;
  localparam int unsigned IncW      = 24;
  localparam int unsigned LimbW     = 12;
  localparam int unsigned NumLimbs  = 4;
  localparam int unsigned OpW       = 3;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CityW-1:0] city_t;
  typedef logic [GenW-1:0]  gen_t;
  typedef logic [IncW-1:0]  inc_t;
  typedef logic [LimbW-1:0] limb_t;

  typedef enum logic [OpW-1:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_RESEED = 3'd2,
    OP_SWAP   = 3'd3,
    OP_SHIFT  = 3'd4,
    OP_BSWAP  = 3'd5,
    OP_INVERT = 3'd6,
    OP_NOP    = 3'd7
  } op_e;

  localparam logic CfgSeed = 1'b0;
  localparam logic CfgInc  = 1'b1;

  localparam limb_t MultLimb [NumLimbs] = '{12'd2107, 12'd4071, 12'd1521, 12'd502};
  localparam gen_t  SeedReset = 48'd1;
  localparam inc_t  IncReset  = 24'd11848339;

  typedef struct packed {
    logic  start;
    addr_t slots;
  } draw_req_t;

  typedef struct packed {
    logic  done;
    addr_t index;
  } draw_rsp_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    city_t wdata;
    logic  re;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

endpackage

[rtl/core/pme_chan_if.sv]
// Valid/ready channel interfaces for the engine's item and result words.
// Depends on pme_pkg for the payload widths.
`timescale 1ns / 1ps

interface pme_in_if import pme_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [AddrW-1:0] entry_index;
  logic [CityW-1:0] entry_value;

  modport source(output valid, output op, output entry_index, output entry_value,
                 input ready);
  modport sink(input valid, input op, input entry_index, input entry_value,
               output ready);
endinterface

interface pme_out_if import pme_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CityW-1:0] read_value;

  modport source(output valid, output read_value, input ready);
  modport sink(input valid, input read_value, output ready);
endinterface

[rtl/core/permutation_mutation_engine_core.sv]
// Permutation mutation engine: tour store, generator and op sequencer.
// Each swap reads both entries, then writes each back in turn. Swap op: one draw, one swap;
// shift: 3 draws, then len*sh swaps; block swap and invert: 2 draws, then len swaps.
// One word in work at a time; the next is taken once the current one sits in the output register.
// Reset (async, active low) gives the identity tour, generator 1, registers to defaults.
`timescale 1ns / 1ps

module permutation_mutation_engine_core import pme_pkg::*; #(
  parameter int unsigned CITIES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pme_in_if.sink     in_s,
  pme_out_if.source  out_s,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  gen_t       cfg_data_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_DRAWGO = 8'b0000_0100,
    S_DRAWW  = 8'b0000_1000,
    S_SWRD   = 8'b0001_0000,
    S_SWWR1  = 8'b0010_0000,
    S_SWWR2  = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_e;

  localparam int unsigned SumW = AddrW + 2;
  localparam logic [SumW-1:0] CitiesS = SumW'(CITIES);
  localparam addr_t KSwap = AddrW'(CITIES - 2);
  localparam addr_t KHalf = AddrW'((CITIES - 1) / 2);

  state_e    state_q, state_d;
  op_e       op_q, op_d;
  addr_t     idx_q, idx_d;
  logic [1:0] ndraw_q, ndraw_d;
  addr_t     len_q, len_d, st_q, st_d, sh_q, sh_d, i_q, i_d, j_q, j_d;
  city_t     res_q, res_d;
  logic      out_valid_q, out_valid_d;
  city_t     out_data_q, out_data_d;
  gen_t      seed_q;
  inc_t      inc_q;

  mem_req_t  mreq;
  city_t     rdata_a, rdata_b;
  draw_req_t dreq;
  draw_rsp_t drsp;
  logic      load;

  logic            accept;
  logic            in_range;
  logic [1:0]      draws_last;
  logic [SumW-1:0] p_w, q_w, pp_w;
  addr_t           p, q;
  logic            last_swap;

  assign accept   = in_s.valid && in_s.ready;
  assign in_s.ready = (state_q == S_IDLE);
  assign out_s.valid = out_valid_q;
  assign out_s.read_value = out_data_q;
  assign in_range = ({1'b0, idx_q} < (AddrW+1)'(CITIES));

  always_comb begin
    unique case (op_q)
      OP_SWAP:  draws_last = 2'd0;
      OP_SHIFT: draws_last = 2'd2;
      default:  draws_last = 2'd1;
    endcase
  end

  always_comb begin
    dreq.start = (state_q == S_DRAWGO);
    dreq.slots = KSwap;
    unique case (op_q)
      OP_SHIFT: begin
        if (ndraw_q == 2'd1) dreq.slots = AddrW'(CitiesS - SumW'(1) - SumW'(len_q));
        else if (ndraw_q == 2'd2) begin
          dreq.slots = AddrW'(CitiesS - SumW'(1) - SumW'(st_q) - SumW'(len_q));
        end
      end
      OP_BSWAP, OP_INVERT: begin
        if (ndraw_q == 2'd0) dreq.slots = KHalf;
        else dreq.slots = AddrW'(CitiesS - (SumW'(len_q) << 1));
      end
      default: dreq.slots = KSwap;
    endcase
  end

  always_comb begin
    pp_w = SumW'(st_q) + SumW'(len_q) - SumW'(i_q) + SumW'(j_q);
    unique case (op_q)
      OP_SHIFT: begin
        p_w = pp_w - SumW'(1);
        q_w = pp_w;
      end
      OP_BSWAP: begin
        p_w = SumW'(st_q) + SumW'(i_q);
        q_w = SumW'(st_q) + SumW'(i_q) + SumW'(len_q);
      end
      OP_INVERT: begin
        p_w = SumW'(st_q) + SumW'(i_q);
        q_w = SumW'(st_q) + (SumW'(len_q) << 1) - SumW'(i_q) - SumW'(1);
      end
      default: begin
        p_w = SumW'(st_q);
        q_w = SumW'(st_q) + SumW'(1);
      end
    endcase
    p = p_w[AddrW-1:0];
    q = q_w[AddrW-1:0];
  end

  always_comb begin
    unique case (op_q)
      OP_SHIFT: last_swap = (i_q == len_q - 1'b1) && (j_q == sh_q - 1'b1);
      OP_BSWAP, OP_INVERT: last_swap = (i_q == len_q - 1'b1);
      default: last_swap = 1'b1;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    ndraw_d     = ndraw_q;
    len_d       = len_q;
    st_d        = st_q;
    sh_d        = sh_q;
    i_d         = i_q;
    j_d         = j_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_s.ready;
    out_data_d  = out_data_q;
    load        = 1'b0;
    mreq        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = op_e'(in_s.op);
          idx_d   = in_s.entry_index;
          res_d   = '0;
          ndraw_d = '0;
          state_d = S_FIN;
          unique case (op_e'(in_s.op))
            OP_WRITE: begin
              mreq.we    = ({1'b0, in_s.entry_index} < (AddrW+1)'(CITIES));
              mreq.waddr = in_s.entry_index;
              mreq.wdata = in_s.entry_value;
            end
            OP_READ: begin
              mreq.re      = 1'b1;
              mreq.raddr_a = in_s.entry_index;
              state_d      = S_READ;
            end
            OP_RESEED: load = 1'b1;
            OP_SWAP, OP_SHIFT, OP_BSWAP, OP_INVERT: state_d = S_DRAWGO;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_READ: begin
        res_d   = in_range ? rdata_a : '0;
        state_d = S_FIN;
      end
      S_DRAWGO: state_d = S_DRAWW;
      S_DRAWW: begin
        if (drsp.done) begin
          if (ndraw_q == 2'd0) begin
            if (op_q == OP_SWAP) st_d = drsp.index;
            else len_d = drsp.index;
          end else if (ndraw_q == 2'd1) begin
            st_d = drsp.index;
          end else begin
            sh_d = drsp.index;
          end
          ndraw_d = ndraw_q + 1'b1;
          if (ndraw_q == draws_last) begin
            i_d     = '0;
            j_d     = '0;
            state_d = S_SWRD;
          end else begin
            state_d = S_DRAWGO;
          end
        end
      end
      S_SWRD: begin
        mreq.re      = 1'b1;
        mreq.raddr_a = p;
        mreq.raddr_b = q;
        state_d      = S_SWWR1;
      end
      S_SWWR1: begin
        mreq.we    = 1'b1;
        mreq.waddr = p;
        mreq.wdata = rdata_b;
        state_d    = S_SWWR2;
      end
      S_SWWR2: begin
        mreq.we    = 1'b1;
        mreq.waddr = q;
        mreq.wdata = rdata_a;
        if (last_swap) begin
          state_d = S_FIN;
        end else begin
          state_d = S_SWRD;
          if (op_q == OP_SHIFT) begin
            if (j_q == sh_q - 1'b1) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_s.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ndraw_q     <= '0;
      seed_q      <= SeedReset;
      inc_q       <= IncReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ndraw_q     <= ndraw_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgSeed) seed_q <= cfg_data_i;
        else inc_q <= cfg_data_i[IncW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    idx_q       <= idx_d;
    len_q       <= len_d;
    st_q        <= st_d;
    sh_q        <= sh_d;
    i_q         <= i_d;
    j_q         <= j_d;
    res_q       <= res_d;
    out_data_q  <= out_data_d;
  end

  pme_tour_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  pme_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .seed_i (seed_q),
    .inc_i  (inc_q),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

endmodule

[rtl/core/pme_lcg.sv]
// 48-bit linear congruential generator with limb-serial multiply and index scaling.
// Depends on pme_pkg.
`timescale 1ns / 1ps

module pme_lcg import pme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  gen_t      seed_i,
  input  inc_t      inc_i,
  input  draw_req_t req_i,
  output draw_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_ADD  = 4'b0100,
    L_IDX  = 4'b1000
  } lcg_state_e;

  localparam int unsigned LimbCntW = $clog2(NumLimbs);

  lcg_state_e           state_q, state_d;
  gen_t                 gen_q, gen_d;
  gen_t                 acc_q, acc_d;
  logic [LimbCntW-1:0]  limb_q, limb_d;
  addr_t                slots_q, slots_d;

  logic [GenW+LimbW-1:0]  part;
  gen_t                   part_sh;
  logic [GenW+AddrW-1:0]  scaled;

  assign part    = gen_q * MultLimb[limb_q];
  assign part_sh = part[GenW-1:0] << (limb_q * LimbW);
  assign scaled  = slots_q * gen_q;

  always_comb begin
    state_d = state_q;
    gen_d   = gen_q;
    acc_d   = acc_q;
    limb_d  = limb_q;
    slots_d = slots_q;
    rsp_o   = '0;
    unique case (state_q)
      L_IDLE: begin
        if (load_i) begin
          gen_d = seed_i | gen_t'(1);
        end else if (req_i.start) begin
          acc_d   = '0;
          limb_d  = '0;
          slots_d = req_i.slots;
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        acc_d  = acc_q + part_sh;
        limb_d = limb_q + 1'b1;
        if (limb_q == LimbCntW'(NumLimbs - 1)) state_d = L_ADD;
      end
      L_ADD: begin
        gen_d   = acc_q + GenW'(inc_i);
        state_d = L_IDX;
      end
      L_IDX: begin
        rsp_o.done  = 1'b1;
        rsp_o.index = scaled[GenW+AddrW-1:GenW] + 1'b1;
        state_d     = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      gen_q   <= SeedReset;
      limb_q  <= '0;
    end else begin
      state_q <= state_d;
      gen_q   <= gen_d;
      limb_q  <= limb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    slots_q <= slots_d;
  end

endmodule

[rtl/core/pme_tour_mem.sv]
// Tour store: 32 x 5 memory, one write port, two registered read ports.
// Entries never written read as their own index. Depends on pme_pkg.
`timescale 1ns / 1ps

module pme_tour_mem import pme_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output city_t    rdata_a_o,
  output city_t    rdata_b_o
);

  city_t                mem [TourDepth];
  logic [TourDepth-1:0] valid_q;
  city_t                rd_a_q, rd_b_q;
  addr_t                ra_a_q, ra_b_q;
  logic                 vld_a_q, vld_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    if (req_i.re) begin
      rd_a_q <= mem[req_i.raddr_a];
      rd_b_q <= mem[req_i.raddr_b];
      ra_a_q <= req_i.raddr_a;
      ra_b_q <= req_i.raddr_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (req_i.we) valid_q[req_i.waddr] <= 1'b1;
      if (req_i.re) begin
        vld_a_q <= valid_q[req_i.raddr_a];
        vld_b_q <= valid_q[req_i.raddr_b];
      end
    end
  end

  assign rdata_a_o = vld_a_q ? rd_a_q : city_t'(ra_a_q);
  assign rdata_b_o = vld_b_q ? rd_b_q : city_t'(ra_b_q);

endmodule

[rtl/core/pme_checker.sv]
// Port-level checks for the engine's channels, bound to permutation_mutation_engine_core.
// Depends on pme_pkg and permutation_mutation_engine_core.
`timescale 1ns / 1ps

module pme_checker import pme_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input city_t out_data_i
);

  logic [1:0] open_q, open_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    open_d = open_q;
    if (in_acc && !out_acc) open_d = open_q + 1'b1;
    else if (!in_acc && out_acc) open_d = open_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) open_q <= '0;
    else open_q <= open_d;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("second word taken while one is in work");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != 2'd0)
    else $error("result word without an accepted input word");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q != 2'd3)
    else $error("more than two words outstanding");

endmodule

bind permutation_mutation_engine_core pme_checker u_pme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_s.valid),
  .in_ready_i  (in_s.ready),
  .out_valid_i (out_s.valid),
  .out_ready_i (out_s.ready),
  .out_data_i  (out_s.read_value)
);
